>>> design/sg3b_pkg.sv
// shared constants, register codes and types of the separable gaussian blur unit
package sg3b_pkg;

  localparam int MAX_WIDTH_DEF    = 4096;
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int WEIGHT_BITS      = 16;
  localparam int ROW_BITS         = 16;
  localparam int COL_OUT_BITS     = 12;
  localparam int FRAME_WIDTH_BITS = 13;
  localparam int APB_ADDR_BITS    = 4;
  localparam int APB_DATA_BITS    = 32;
  localparam int ROUND_BIAS       = 1 << (WEIGHT_BITS - 1);

  // register values after reset
  localparam logic [FRAME_WIDTH_BITS-1:0] FRAME_WIDTH_RST   = 13'd4096;
  localparam logic [ROW_BITS-1:0]         FRAME_HEIGHT_RST  = 16'd1;
  localparam logic [WEIGHT_BITS-1:0]      EDGE_WEIGHT_RST   = 16'd16384;
  localparam logic [WEIGHT_BITS-1:0]      CENTER_WEIGHT_RST = 16'd32768;

  // register index, taken from the word address
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_EDGE_WEIGHT,
    REG_CENTER_WEIGHT
  } reg_idx_e;

  typedef struct packed {
    logic [FRAME_WIDTH_BITS-1:0] frame_width;
    logic [ROW_BITS-1:0]         frame_height;
    logic [WEIGHT_BITS-1:0]      edge_weight;
    logic [WEIGHT_BITS-1:0]      center_weight;
  } cfg_t;

  // control that travels with one horizontal value through the line-store pipeline
  typedef struct packed {
    logic [ROW_BITS-1:0] row;
    logic                last_row;
    logic                last_col;
    logic                final_op;
  } op_flags_t;

endpackage

>>> design/sg3b_stream_if.sv
// sample and result stream interfaces with valid/ready handshake
interface sg3b_in_if #(
  parameter int SAMPLE_BITS = sg3b_pkg::SAMPLE_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface sg3b_out_if #(
  parameter int SAMPLE_BITS = sg3b_pkg::SAMPLE_BITS_DEF
) ();
  import sg3b_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [SAMPLE_BITS-1:0]  out_sample;
  logic [ROW_BITS-1:0]     out_row;
  logic [COL_OUT_BITS-1:0] out_column;
  logic                    end_of_frame;
  logic                    last;

  modport source (output valid, output out_sample, output out_row, output out_column,
                  output end_of_frame, output last, input ready);
  modport sink   (input valid, input out_sample, input out_row, input out_column,
                  input end_of_frame, input last, output ready);
endinterface

>>> design/sg3b_ram.sv
// generic single-clock ram, one write and one registered read port
module sg3b_ram #(
  parameter int WIDTH = 2 * sg3b_pkg::SAMPLE_BITS_DEF,
  parameter int DEPTH = sg3b_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> design/sg3b_cfg.sv
// apb register block holding frame size and filter weights
module sg3b_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sg3b_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [sg3b_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [sg3b_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                 pready,
  output sg3b_pkg::cfg_t                       cfg_o
);
  import sg3b_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[APB_ADDR_BITS-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  // register writes in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width   <= FRAME_WIDTH_RST;
      cfg_q.frame_height  <= FRAME_HEIGHT_RST;
      cfg_q.edge_weight   <= EDGE_WEIGHT_RST;
      cfg_q.center_weight <= CENTER_WEIGHT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_FRAME_WIDTH:   cfg_q.frame_width   <= pwdata[FRAME_WIDTH_BITS-1:0];
        REG_FRAME_HEIGHT:  cfg_q.frame_height  <= pwdata[ROW_BITS-1:0];
        REG_EDGE_WEIGHT:   cfg_q.edge_weight   <= pwdata[WEIGHT_BITS-1:0];
        REG_CENTER_WEIGHT: cfg_q.center_weight <= pwdata[WEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // read-back mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_FRAME_WIDTH:   prdata = APB_DATA_BITS'(cfg_q.frame_width);
      REG_FRAME_HEIGHT:  prdata = APB_DATA_BITS'(cfg_q.frame_height);
      REG_EDGE_WEIGHT:   prdata = APB_DATA_BITS'(cfg_q.edge_weight);
      REG_CENTER_WEIGHT: prdata = APB_DATA_BITS'(cfg_q.center_weight);
      default:           prdata = '0;
    endcase
  end

endmodule

>>> design/sg3b_front.sv
// raster position tracking, horizontal tap window and issue of horizontal operations
module sg3b_front #(
  parameter int MAX_WIDTH   = sg3b_pkg::MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = sg3b_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sg3b_pkg::cfg_t                cfg_i,
  sg3b_in_if.sink                       in_ch,
  output logic                          op_valid_o,
  input  logic                          op_ready_i,
  output logic [SAMPLE_BITS:0]          op_outer_o,
  output logic [SAMPLE_BITS-1:0]        op_center_o,
  output logic [$clog2(MAX_WIDTH)-1:0]  op_x_o,
  output sg3b_pkg::op_flags_t           op_flags_o
);
  import sg3b_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int CW = (XW + 1 > FRAME_WIDTH_BITS) ? XW + 1 : FRAME_WIDTH_BITS;

  logic [SAMPLE_BITS-1:0] d1_q, d2_q;
  logic [XW-1:0]          col_q, col_d;
  logic [ROW_BITS-1:0]    row_q, row_d;

  logic                   s0_valid_q, s0_valid_d;
  logic [SAMPLE_BITS:0]   s0_outer_q;
  logic [SAMPLE_BITS-1:0] s0_center_q;
  logic [XW-1:0]          s0_x_q;
  op_flags_t              s0_flags_q;

  logic                   pend_valid_q, pend_valid_d;
  logic [SAMPLE_BITS:0]   pend_outer_q;
  logic [SAMPLE_BITS-1:0] pend_center_q;
  logic [XW-1:0]          pend_x_q;
  op_flags_t              pend_flags_q;

  logic [CW-1:0]          fw, fw_m1;
  logic [XW-1:0]          col_lim;
  logic [ROW_BITS-1:0]    row_lim;
  logic                   last_col, last_row, col_zero, col_one;
  logic                   s0_load_ok, accept, pend_move;

  logic                   gen1, gen2;
  logic [SAMPLE_BITS-1:0] left;
  logic [SAMPLE_BITS:0]   outer1, outer2;
  logic [SAMPLE_BITS-1:0] center1, center2;
  logic [XW-1:0]          x1, x2;
  op_flags_t              flags1, flags2;

  // effective frame limits: zero counts as one, width clamps to the line store
  assign fw    = CW'(cfg_i.frame_width);
  assign fw_m1 = fw - CW'(1);

  always_comb begin
    if (fw == '0) begin
      col_lim = '0;
    end else if (fw > CW'(MAX_WIDTH)) begin
      col_lim = XW'(MAX_WIDTH - 1);
    end else begin
      col_lim = fw_m1[XW-1:0];
    end
  end

  assign row_lim  = (cfg_i.frame_height == '0) ? '0 : cfg_i.frame_height - ROW_BITS'(1);
  assign last_col = col_q >= col_lim;
  assign last_row = row_q >= row_lim;
  assign col_zero = col_q == '0;
  assign col_one  = col_q == XW'(1);

  // handshake: a second operation at row end holds off the next sample
  assign s0_load_ok  = !s0_valid_q || op_ready_i;
  assign in_ch.ready = !pend_valid_q && s0_load_ok;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pend_move   = pend_valid_q && s0_load_ok;

  // horizontal value for the previous column, or the lone column of a one-wide row
  always_comb begin
    left            = col_one ? in_ch.sample : d2_q;
    gen1            = 1'b1;
    x1              = col_q - XW'(1);
    outer1          = {1'b0, left} + {1'b0, in_ch.sample};
    center1         = d1_q;
    flags1.row      = row_q;
    flags1.last_row = last_row;
    flags1.last_col = 1'b0;
    flags1.final_op = !last_col;
    if (col_zero) begin
      gen1            = last_col;
      x1              = '0;
      outer1          = {in_ch.sample, 1'b0};
      center1         = in_ch.sample;
      flags1.last_col = 1'b1;
      flags1.final_op = 1'b1;
    end
  end

  // horizontal value for the current column when it ends the row (reflected right edge)
  always_comb begin
    gen2            = !col_zero && last_col;
    x2              = col_q;
    outer2          = {d1_q, 1'b0};
    center2         = in_ch.sample;
    flags2.row      = row_q;
    flags2.last_row = last_row;
    flags2.last_col = 1'b1;
    flags2.final_op = 1'b1;
  end

  // raster counters
  always_comb begin
    col_d = col_q + XW'(1);
    row_d = row_q;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + ROW_BITS'(1);
    end
  end

  always_comb begin
    if (accept) begin
      s0_valid_d = gen1;
    end else if (pend_move) begin
      s0_valid_d = 1'b1;
    end else if (s0_load_ok) begin
      s0_valid_d = 1'b0;
    end else begin
      s0_valid_d = s0_valid_q;
    end
  end

  always_comb begin
    if (accept) begin
      pend_valid_d = gen2;
    end else if (pend_move) begin
      pend_valid_d = 1'b0;
    end else begin
      pend_valid_d = pend_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q         <= '0;
      d2_q         <= '0;
      col_q        <= '0;
      row_q        <= '0;
      s0_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      s0_valid_q   <= s0_valid_d;
      pend_valid_q <= pend_valid_d;
      if (accept) begin
        d2_q  <= d1_q;
        d1_q  <= in_ch.sample;
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  // operation payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_outer_q    <= outer1;
      s0_center_q   <= center1;
      s0_x_q        <= x1;
      s0_flags_q    <= flags1;
      pend_outer_q  <= outer2;
      pend_center_q <= center2;
      pend_x_q      <= x2;
      pend_flags_q  <= flags2;
    end else if (pend_move) begin
      s0_outer_q  <= pend_outer_q;
      s0_center_q <= pend_center_q;
      s0_x_q      <= pend_x_q;
      s0_flags_q  <= pend_flags_q;
    end
  end

  assign op_valid_o  = s0_valid_q;
  assign op_outer_o  = s0_outer_q;
  assign op_center_o = s0_center_q;
  assign op_x_o      = s0_x_q;
  assign op_flags_o  = s0_flags_q;

endmodule

>>> design/sg3b_pipe.sv
// horizontal taps, line-store read-modify-write, vertical taps and result sequencing
module sg3b_pipe #(
  parameter int MAX_WIDTH   = sg3b_pkg::MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = sg3b_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sg3b_pkg::cfg_t                cfg_i,
  input  logic                          op_valid_i,
  output logic                          op_ready_o,
  input  logic [SAMPLE_BITS:0]          op_outer_i,
  input  logic [SAMPLE_BITS-1:0]        op_center_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  op_x_i,
  input  sg3b_pkg::op_flags_t           op_flags_i,
  sg3b_out_if.source                    out_ch
);
  import sg3b_pkg::*;

  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int SB   = SAMPLE_BITS;
  localparam int PE_W = WEIGHT_BITS + SB + 1;
  localparam int PC_W = WEIGHT_BITS + SB;
  localparam int SW   = WEIGHT_BITS + SB + 2;

  // sum of the tap products, rounded half up, saturated to the sample range
  function automatic logic [SB-1:0] round_sat(input logic [PE_W-1:0] pe,
                                              input logic [PC_W-1:0] pc);
    logic [SW-1:0] acc;
    acc = SW'(pe) + SW'(pc) + SW'(ROUND_BIAS);
    if (|acc[SW-1:WEIGHT_BITS+SB]) begin
      return '1;
    end
    return acc[WEIGHT_BITS+SB-1:WEIGHT_BITS];
  endfunction

  // stage 1: horizontal products
  logic            s1_valid_q;
  logic [PE_W-1:0] s1_pe_q;
  logic [PC_W-1:0] s1_pc_q;
  logic [XW-1:0]   s1_x_q;
  op_flags_t       s1_flags_q;

  // stage 2: horizontal value, line-store data
  logic            s2_valid_q;
  logic [SB-1:0]   s2_h_q;
  logic [XW-1:0]   s2_x_q;
  op_flags_t       s2_flags_q;
  logic            fwd_sel_q, fwd_sel_d;
  logic [2*SB-1:0] fwd_data_q;

  // stage 3: vertical operands
  logic            s3_valid_q;
  logic [SB:0]     s3_a_outer_q, s3_b_outer_q;
  logic [SB-1:0]   s3_a_center_q, s3_b_center_q;
  logic [XW-1:0]   s3_x_q;
  op_flags_t       s3_flags_q;

  // stage 4: vertical products
  logic            s4_valid_q;
  logic [PE_W-1:0] s4_pae_q, s4_pbe_q;
  logic [PC_W-1:0] s4_pac_q, s4_pbc_q;
  logic [XW-1:0]   s4_x_q;
  op_flags_t       s4_flags_q;
  logic            s4_has_a_q, s4_has_b_q;

  // result register: upper row first, then the reflected last row
  logic                    has_a_q, has_b_q;
  logic [SB-1:0]           a_sample_q, b_sample_q;
  logic [ROW_BITS-1:0]     a_row_q, b_row_q;
  logic [COL_OUT_BITS-1:0] col_q;
  logic                    a_last_q, b_last_q, b_eof_q;

  logic            s2_ready, s3_ready, s4_ready, s4_results;
  logic            out_fire, out_load_ok, out_load;
  logic            ram_re, ram_we;
  logic [2*SB-1:0] ram_rdata, ram_wdata, mem_word;
  logic [SB-1:0]   mem_older, mem_newer;
  logic            row_is_zero, row_is_one;
  logic [SB:0]     a_outer, b_outer;

  // stall chain
  assign out_fire    = out_ch.valid && out_ch.ready;
  assign out_load_ok = (!has_a_q && !has_b_q) || (out_fire && !(has_a_q && has_b_q));
  assign s4_results  = s4_has_a_q || s4_has_b_q;
  assign s4_ready    = !s4_valid_q || !s4_results || out_load_ok;
  assign s3_ready    = !s3_valid_q || s4_ready;
  assign s2_ready    = !s2_valid_q || s3_ready;
  assign op_ready_o  = !s1_valid_q || s2_ready;
  assign out_load    = s4_valid_q && s4_results && out_load_ok;

  // line store: older row in the upper half, newer row in the lower half
  assign ram_re    = s1_valid_q && s2_ready;
  assign ram_we    = s2_valid_q && s3_ready;
  assign mem_word  = fwd_sel_q ? fwd_data_q : ram_rdata;
  assign mem_older = mem_word[2*SB-1:SB];
  assign mem_newer = mem_word[SB-1:0];
  assign ram_wdata = {mem_newer, s2_h_q};

  // a read that meets the write of the same column takes the written word
  assign fwd_sel_d = s2_valid_q && (s2_x_q == s1_x_q);

  sg3b_ram #(
    .WIDTH (2 * SB),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s2_x_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (s1_x_q),
    .rdata_o (ram_rdata)
  );

  // vertical operands, reflected at the top and bottom rows
  assign row_is_zero = s2_flags_q.row == '0;
  assign row_is_one  = s2_flags_q.row == ROW_BITS'(1);
  assign a_outer     = row_is_one ? {s2_h_q, 1'b0} : {1'b0, mem_older} + {1'b0, s2_h_q};
  assign b_outer     = row_is_zero ? {s2_h_q, 1'b0} : {mem_newer, 1'b0};

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      has_a_q    <= 1'b0;
      has_b_q    <= 1'b0;
    end else begin
      if (op_ready_o) s1_valid_q <= op_valid_i;
      if (s2_ready)   s2_valid_q <= s1_valid_q;
      if (s3_ready)   s3_valid_q <= s2_valid_q;
      if (s4_ready)   s4_valid_q <= s3_valid_q;
      if (out_load) begin
        has_a_q <= s4_has_a_q;
        has_b_q <= s4_has_b_q;
      end else if (out_fire) begin
        if (has_a_q) begin
          has_a_q <= 1'b0;
        end else begin
          has_b_q <= 1'b0;
        end
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (op_ready_o) begin
      s1_pe_q    <= PE_W'(cfg_i.edge_weight) * PE_W'(op_outer_i);
      s1_pc_q    <= PC_W'(cfg_i.center_weight) * PC_W'(op_center_i);
      s1_x_q     <= op_x_i;
      s1_flags_q <= op_flags_i;
    end
    if (s2_ready) begin
      s2_h_q     <= round_sat(s1_pe_q, s1_pc_q);
      s2_x_q     <= s1_x_q;
      s2_flags_q <= s1_flags_q;
      fwd_sel_q  <= fwd_sel_d;
      fwd_data_q <= ram_wdata;
    end
    if (s3_ready) begin
      s3_a_outer_q  <= a_outer;
      s3_a_center_q <= mem_newer;
      s3_b_outer_q  <= b_outer;
      s3_b_center_q <= s2_h_q;
      s3_x_q        <= s2_x_q;
      s3_flags_q    <= s2_flags_q;
    end
    if (s4_ready) begin
      s4_pae_q   <= PE_W'(cfg_i.edge_weight) * PE_W'(s3_a_outer_q);
      s4_pac_q   <= PC_W'(cfg_i.center_weight) * PC_W'(s3_a_center_q);
      s4_pbe_q   <= PE_W'(cfg_i.edge_weight) * PE_W'(s3_b_outer_q);
      s4_pbc_q   <= PC_W'(cfg_i.center_weight) * PC_W'(s3_b_center_q);
      s4_x_q     <= s3_x_q;
      s4_flags_q <= s3_flags_q;
      s4_has_a_q <= s3_flags_q.row != '0;
      s4_has_b_q <= s3_flags_q.last_row;
    end
    if (out_load) begin
      a_sample_q <= round_sat(s4_pae_q, s4_pac_q);
      b_sample_q <= round_sat(s4_pbe_q, s4_pbc_q);
      a_row_q    <= s4_flags_q.row - ROW_BITS'(1);
      b_row_q    <= s4_flags_q.row;
      col_q      <= COL_OUT_BITS'(s4_x_q);
      a_last_q   <= s4_flags_q.final_op && !s4_flags_q.last_row;
      b_last_q   <= s4_flags_q.final_op;
      b_eof_q    <= s4_flags_q.last_col;
    end
  end

  // result channel
  assign out_ch.valid        = has_a_q || has_b_q;
  assign out_ch.out_sample   = has_a_q ? a_sample_q : b_sample_q;
  assign out_ch.out_row      = has_a_q ? a_row_q : b_row_q;
  assign out_ch.out_column   = col_q;
  assign out_ch.end_of_frame = has_a_q ? 1'b0 : b_eof_q;
  assign out_ch.last         = has_a_q ? a_last_q : b_last_q;

endmodule

>>> design/separable_gauss3_reflect_blur_unit.sv
// Separable 3x3 gaussian blur with reflect-101 borders over a raster luminance stream.
// A result passes the front operation register, each pipe stage and the result register. One
// sample per cycle inside a row while results are taken; a row-ending sample issues two
// operations and holds off the next one. In the last row of a frame taller than one row each
// sample yields two results on the single result port. Reset clears counters, tap window and
// pipeline, and loads the register defaults; the line store is not cleared, valid once written.
module separable_gauss3_reflect_blur_unit #(
  parameter int MAX_WIDTH   = sg3b_pkg::MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = sg3b_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  sg3b_in_if.sink                            in_ch,
  sg3b_out_if.source                         out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sg3b_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [sg3b_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [sg3b_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready
);
  import sg3b_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);

  cfg_t                   cfg;
  logic                   op_valid, op_ready;
  logic [SAMPLE_BITS:0]   op_outer;
  logic [SAMPLE_BITS-1:0] op_center;
  logic [XW-1:0]          op_x;
  op_flags_t              op_flags;

  // register block
  sg3b_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // raster tracking and horizontal operation issue
  sg3b_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_ch       (in_ch),
    .op_valid_o  (op_valid),
    .op_ready_i  (op_ready),
    .op_outer_o  (op_outer),
    .op_center_o (op_center),
    .op_x_o      (op_x),
    .op_flags_o  (op_flags)
  );

  // filter pipeline around the line store
  sg3b_pipe #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .op_valid_i  (op_valid),
    .op_ready_o  (op_ready),
    .op_outer_i  (op_outer),
    .op_center_i (op_center),
    .op_x_i      (op_x),
    .op_flags_i  (op_flags),
    .out_ch      (out_ch)
  );

`ifndef NO_ASSERTIONS
  // a stalled operation keeps its column until the pipeline takes it
  a_op_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_valid && !op_ready |=> op_valid && $stable(op_x) && $stable(op_flags))
    else $error("stalled line-store operation changed");

  // a row-ending operation is always the last one of its sample
  a_row_end_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_valid && op_flags.last_col |-> op_flags.final_op)
    else $error("row-ending operation not marked final");

  // the frame-ending result closes the results of its sample
  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.end_of_frame |-> out_ch.last)
    else $error("end of frame without last");
`endif

endmodule

>>> tb/sg3b_blur_checker.sv
// passive checker: snoops config writes and both streams, predicts blurred pixels, compares
`timescale 1ns / 1ps

module sg3b_blur_checker
  import sg3b_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  sg3b_in_if                       in_mon,
  sg3b_out_if                      out_mon,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  input  logic                     pready,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o,
  output int unsigned              results_o
);

  typedef struct packed {
    logic [15:0]             value;
    logic [ROW_BITS-1:0]     row;
    logic [COL_OUT_BITS-1:0] column;
    logic                    eof;
    logic                    last;
  } blur_px_t;

  // expected blurred pixels, oldest first
  blur_px_t    blurred_q[$];

  // shadow copy of the registers and of the filter state
  cfg_t        cfg;
  logic [15:0] px_d1;
  logic [15:0] px_d2;
  logic [11:0] col_cnt;
  logic [15:0] row_cnt;
  logic [15:0] older_line [MAX_WIDTH_DEF];
  logic [15:0] newer_line [MAX_WIDTH_DEF];
  int unsigned mismatches;
  int unsigned checked;

  // symmetric 3-tap weighting, rounded half up and saturated
  function automatic logic [15:0] weigh3(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] c);
    logic [63:0] acc;
    acc = 64'(cfg.edge_weight) * a + 64'(cfg.center_weight) * b
        + 64'(cfg.edge_weight) * c;
    acc = (acc + ROUND_BIAS) >> WEIGHT_BITS;
    return (acc > 64'hFFFF) ? 16'hFFFF : acc[15:0];
  endfunction

  function automatic void push_px(input logic [15:0] value, input logic [15:0] row,
                                  input int unsigned col, input logic eof);
    blur_px_t px;
    px.value  = value;
    px.row    = row;
    px.column = col[COL_OUT_BITS-1:0];
    px.eof    = eof;
    px.last   = 1'b0;
    blurred_q.push_back(px);
  endfunction

  // vertical pass for one finished horizontal value at column x
  function automatic void emit_column(input int unsigned x, input logic [15:0] h,
                                      input logic last_row, input logic last_col);
    logic [15:0] older;
    logic [15:0] newer;
    older = older_line[x];
    newer = newer_line[x];
    if (row_cnt >= 1) begin
      push_px((row_cnt == 1) ? weigh3(h, newer, h) : weigh3(older, newer, h),
              row_cnt - 16'd1, x, 1'b0);
    end
    if (last_row) begin
      push_px((row_cnt == 0) ? weigh3(h, h, h) : weigh3(newer, h, newer),
              row_cnt, x, last_col);
    end
    older_line[x] = newer;
    newer_line[x] = h;
  endfunction

  // one accepted sample: horizontal pass, then the vertical outputs it completes
  function automatic void blur_step(input logic [15:0] s);
    int unsigned w;
    int unsigned hgt;
    int unsigned c;
    int unsigned n0;
    logic        last_col;
    logic        last_row;
    w = cfg.frame_width;
    if (w == 0) w = 1;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    hgt = (cfg.frame_height == 0) ? 1 : cfg.frame_height;
    c = col_cnt;
    last_col = (c >= w - 1);
    last_row = (row_cnt >= hgt - 1);
    n0 = blurred_q.size();
    if (c == 0) begin
      if (last_col) emit_column(0, weigh3(s, s, s), last_row, 1'b1);
    end else begin
      emit_column(c - 1, weigh3((c == 1) ? s : px_d2, px_d1, s), last_row, 1'b0);
      if (last_col) emit_column(c, weigh3(px_d1, s, px_d1), last_row, 1'b1);
    end
    if (blurred_q.size() > n0) blurred_q[blurred_q.size() - 1].last = 1'b1;
    px_d2 = px_d1;
    px_d1 = s;
    if (last_col) begin
      col_cnt = '0;
      row_cnt = last_row ? 16'd0 : row_cnt + 16'd1;
    end else begin
      col_cnt = 12'(c + 1);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    blur_px_t want;
    if (!rst_ni) begin
      cfg        = '{FRAME_WIDTH_RST, FRAME_HEIGHT_RST, EDGE_WEIGHT_RST, CENTER_WEIGHT_RST};
      px_d1      = '0;
      px_d2      = '0;
      col_cnt    = '0;
      row_cnt    = '0;
      mismatches = 0;
      checked    = 0;
      blurred_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      results_o    <= 0;
    end else begin
      // register write transaction
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[APB_ADDR_BITS-1:2]))
          REG_FRAME_WIDTH:   cfg.frame_width   = pwdata[FRAME_WIDTH_BITS-1:0];
          REG_FRAME_HEIGHT:  cfg.frame_height  = pwdata[ROW_BITS-1:0];
          REG_EDGE_WEIGHT:   cfg.edge_weight   = pwdata[WEIGHT_BITS-1:0];
          REG_CENTER_WEIGHT: cfg.center_weight = pwdata[WEIGHT_BITS-1:0];
          default: ;
        endcase
      end
      // sample transaction
      if (in_mon.valid && in_mon.ready) blur_step(in_mon.sample);
      // result transaction
      if (out_mon.valid && out_mon.ready) begin
        checked++;
        if (blurred_q.size() == 0) begin
          mismatches++;
          $error("unexpected result: out_sample %0d out_row %0d out_column %0d",
                 out_mon.out_sample, out_mon.out_row, out_mon.out_column);
        end else begin
          want = blurred_q.pop_front();
          if (out_mon.out_sample !== want.value) begin
            mismatches++;
            $error("out_sample: expected %0d, actual %0d", want.value, out_mon.out_sample);
          end
          if (out_mon.out_row !== want.row) begin
            mismatches++;
            $error("out_row: expected %0d, actual %0d", want.row, out_mon.out_row);
          end
          if (out_mon.out_column !== want.column) begin
            mismatches++;
            $error("out_column: expected %0d, actual %0d", want.column, out_mon.out_column);
          end
          if (out_mon.end_of_frame !== want.eof) begin
            mismatches++;
            $error("end_of_frame: expected %0d, actual %0d", want.eof, out_mon.end_of_frame);
          end
          if (out_mon.last !== want.last) begin
            mismatches++;
            $error("last: expected %0d, actual %0d", want.last, out_mon.last);
          end
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= blurred_q.size();
      results_o    <= checked;
    end
  end

endmodule

>>> tb/tb_separable_gauss3_reflect_blur_unit.sv
// testbench top: clock, reset, register writes, sample stimulus, result back-pressure, verdict
`timescale 1ns / 1ps

module tb_separable_gauss3_reflect_blur_unit;
  import sg3b_pkg::*;

  // run limit covers the slowest run, with samples gapped and results stalled
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned MAX_GAP      = 24;
  localparam int unsigned DRAIN_TAIL   = 12;
  localparam int unsigned RANDOM_ITEMS = 330;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;
  logic                     calm;
  int unsigned              stall_left;
  int unsigned              cycles;
  int unsigned              samples_sent;
  int unsigned              frames_sent;
  int unsigned              fail_count;
  int unsigned              pending;
  int unsigned              results;

  sg3b_in_if  in_ch ();
  sg3b_out_if out_ch ();

  separable_gauss3_reflect_blur_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sg3b_blur_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run guard
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // mostly short idle stretches, now and then a long one
  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, MAX_GAP);
  endfunction

  function automatic logic [15:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'h0000;
    if (r < 16) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  // result back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= gap_len() - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // one sample transaction, optionally after an idle gap
  task automatic send_px(input logic [15:0] s);
    logic took;
    if (!calm && $urandom_range(0, 2) == 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap_len()) @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do begin
      @(negedge clk_i);
      took = in_ch.ready;
      @(posedge clk_i);
    end while (!took);
    samples_sent++;
  endtask

  // hold the sender until every expected result is in, then let the pipeline settle
  task automatic wait_drain(input int unsigned settle);
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // setup and access phase; the caller releases the bus after its last write
  task automatic apb_write(input reg_idx_e idx, input logic [APB_DATA_BITS-1:0] value);
    logic took;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      took = pready;
      @(posedge clk_i);
    end while (!took);
  endtask

  // new frame setup, only once the unit is idle
  task automatic configure(input int unsigned w, input int unsigned h, input int unsigned e,
                           input int unsigned c);
    wait_drain(DRAIN_TAIL);
    apb_write(REG_FRAME_WIDTH, w);
    apb_write(REG_FRAME_HEIGHT, h);
    apb_write(REG_EDGE_WEIGHT, e);
    apb_write(REG_CENTER_WEIGHT, c);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    frames_sent++;
  endtask

  task automatic run_frame(input int unsigned w_eff, input int unsigned h_eff);
    for (int unsigned i = 0; i < w_eff * h_eff; i++) begin
      if (!calm && $urandom_range(0, 59) == 0) wait_drain(0);
      send_px(pick_sample());
    end
  endtask

  initial begin
    int unsigned random_done;
    int unsigned r;
    int unsigned w_reg;
    int unsigned h_reg;
    int unsigned e_w;
    int unsigned c_w;
    int unsigned w_eff;
    int unsigned h_eff;
    rst_ni       = 1'b0;
    calm         = 1'b1;
    stall_left   = 0;
    samples_sent = 0;
    frames_sent  = 0;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults straight after reset: start of a full-width single-row frame,
    // then a narrower width closes the row at the next sample
    frames_sent++;
    run_frame(32, 1);
    configure(33, 1, 16384, 32768);
    send_px(pick_sample());

    // single pixel frame
    configure(1, 1, 16384, 32768);
    send_px(16'hFFFF);
    // zero width acts as one column
    configure(0, 3, 16384, 32768);
    send_px(16'h0000);
    send_px(16'hFFFF);
    send_px(16'h1234);
    // zero height acts as one row
    configure(3, 0, 21845, 21846);
    send_px(16'hFFFF);
    send_px(16'h0000);
    send_px(16'hFFFF);
    // largest center weight, sum saturates
    configure(2, 2, 32768, 65535);
    repeat (4) send_px(16'hFFFF);
    // zero weights, with the sender held mid-frame until all results are in
    calm = 1'b0;
    configure(4, 2, 0, 0);
    repeat (4) send_px(pick_sample());
    wait_drain(0);
    repeat (4) send_px(pick_sample());

    // oversize width code clamps to the line-store size, so a short run does not end the row
    calm = 1'b1;
    configure(8191, 1, 10923, 43690);
    run_frame(16, 1);
    configure(17, 1, 10923, 43690);
    send_px(pick_sample());

    // random frames
    random_done = 0;
    while (random_done < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 3) w_reg = 0;
      else if (r < 75) w_reg = $urandom_range(1, 8);
      else if (r < 97) w_reg = $urandom_range(9, 32);
      else w_reg = $urandom_range(100, 200);
      r = $urandom_range(0, 99);
      if (r < 3) h_reg = 0;
      else if (r < 90) h_reg = $urandom_range(1, 6);
      else h_reg = $urandom_range(7, 12);
      if (w_reg > 32) h_reg = $urandom_range(1, 3);
      r = $urandom_range(0, 99);
      if (r < 55) begin
        e_w = $urandom_range(0, 32768);
        c_w = (65536 - 2 * e_w > 65535) ? 65535 : 65536 - 2 * e_w;
      end else if (r < 70) begin
        e_w = ($urandom_range(0, 1) == 0) ? 0 : 32768;
        c_w = ($urandom_range(0, 1) == 0) ? 0 : 65535;
      end else begin
        e_w = $urandom_range(0, 65535);
        c_w = $urandom_range(0, 65535);
      end
      w_eff = (w_reg == 0) ? 1 : w_reg;
      h_eff = (h_reg == 0) ? 1 : h_reg;
      calm = ($urandom_range(0, 4) == 0);
      configure(w_reg, h_reg, e_w, c_w);
      run_frame(w_eff, h_eff);
      random_done += w_eff * h_eff;
    end

    // tallest frame, left open at the end of the run
    calm = 1'b0;
    configure($urandom_range(1, 4), 65535, 16384, 32768);
    run_frame(1, 40);

    wait_drain(DRAIN_TAIL);
    $display("summary: %0d frames, %0d samples sent, %0d blurred results checked",
             frames_sent, samples_sent, results);
    $display("summary: widths 1 to 200 with zero and oversize codes, heights to 65535");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/sg3b_pkg.sv
design/sg3b_stream_if.sv
design/sg3b_ram.sv
design/sg3b_cfg.sv
design/sg3b_front.sv
design/sg3b_pipe.sv
design/separable_gauss3_reflect_blur_unit.sv
tb/sg3b_blur_checker.sv
tb/tb_separable_gauss3_reflect_blur_unit.sv
